// ===== hdl/srdf_pkg.sv =====
// ----------------------------------------------------------------------------
// srdf_pkg
// Shared constants, command codes and inter-module types for the shadow
// register file with dirty tracking and group flush.
// ----------------------------------------------------------------------------
package srdf_pkg;

  localparam int NUM_REGS    = 256;
  localparam int GROUP_SIZE  = 32;
  localparam int NUM_GROUPS  = (NUM_REGS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int DIRTY_BITS  = NUM_GROUPS * GROUP_SIZE;

  localparam int CMD_W       = 2;
  localparam int IDX_W       = 8;
  localparam int PAY_W       = 24;
  localparam int WORD_W      = 32;
  localparam int GRP_W       = 3;

  localparam int ADDR_W      = $clog2(NUM_REGS);
  localparam int CNT_W       = $clog2(GROUP_SIZE);
  localparam int WALK_W      = $clog2(NUM_REGS + 1);

  localparam logic [CMD_W-1:0] CMD_CACHED   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MASKED   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNCACHED = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH    = 2'd3;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } srdf_mem_req_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [PAY_W-1:0] arg;
    logic [PAY_W-1:0] mask;
  } srdf_alu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              eq;
  } srdf_alu_rsp_t;

endpackage

// ===== hdl/srdf_if.sv =====
// ----------------------------------------------------------------------------
// srdf_if
// Valid/ready channels: input command transactions and emitted words.
// ----------------------------------------------------------------------------
interface srdf_item_if;
  logic                           valid;
  logic                           ready;
  logic [srdf_pkg::CMD_W-1:0]     cmd;
  logic [srdf_pkg::IDX_W-1:0]     reg_index;
  logic [srdf_pkg::PAY_W-1:0]     arg;
  logic [srdf_pkg::PAY_W-1:0]     bit_mask;
  logic [srdf_pkg::GRP_W-1:0]     group_index;

  modport source (output valid, cmd, reg_index, arg, bit_mask, group_index, input ready);
  modport sink   (input valid, cmd, reg_index, arg, bit_mask, group_index, output ready);
endinterface

interface srdf_result_if;
  logic                           valid;
  logic                           ready;
  logic [srdf_pkg::WORD_W-1:0]    command_word;
  logic                           last;

  modport source (output valid, command_word, last, input ready);
  modport sink   (input valid, command_word, last, output ready);
endinterface

// ===== hdl/srdf_alu.sv =====
// ----------------------------------------------------------------------------
// srdf_alu
// Shared merge and compare unit: builds the new word for a write and
// compares it with the stored one, or checks a stored index on flush.
// ----------------------------------------------------------------------------
module srdf_alu (
  input  srdf_pkg::srdf_alu_req_t          req_i,
  input  logic [srdf_pkg::WORD_W-1:0]      old_i,
  output srdf_pkg::srdf_alu_rsp_t          rsp_o
);

  logic [srdf_pkg::WORD_W-1:0] word;

  always_comb begin
    unique case (req_i.cmd)
      srdf_pkg::CMD_MASKED: begin
        word = {req_i.idx | old_i[srdf_pkg::WORD_W-1:srdf_pkg::PAY_W],
                (old_i[srdf_pkg::PAY_W-1:0] & ~req_i.mask) | (req_i.arg & req_i.mask)};
      end
      default: begin
        word = {req_i.idx, req_i.arg};
      end
    endcase
  end

  assign rsp_o.word = word;
  assign rsp_o.eq   = (req_i.cmd == srdf_pkg::CMD_FLUSH)
                    ? (old_i[srdf_pkg::WORD_W-1:srdf_pkg::PAY_W] == req_i.idx)
                    : (word == old_i);

endmodule

// ===== hdl/srdf_store.sv =====
// ----------------------------------------------------------------------------
// srdf_store
// Shadow word memory, one write and one registered read per cycle;
// entries never written read as zero.
// ----------------------------------------------------------------------------
module srdf_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  srdf_pkg::srdf_mem_req_t          req_i,
  output logic [srdf_pkg::WORD_W-1:0]      rd_data_o
);

  logic [srdf_pkg::WORD_W-1:0]   mem_q [srdf_pkg::NUM_REGS];
  logic [srdf_pkg::NUM_REGS-1:0] valid_q;
  logic [srdf_pkg::WORD_W-1:0]   rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= valid_q[req_i.rd_addr] ? mem_q[req_i.rd_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/srdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// srdf_ctrl
// Sequencer: read-modify-write of one entry, dirty bit upkeep, and the
// group flush walk with a one-word hold to mark the final word.
// ----------------------------------------------------------------------------
module srdf_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  srdf_item_if.sink                        item_i,
  srdf_result_if.source                    result_o,
  output srdf_pkg::srdf_mem_req_t          mem_req_o,
  input  logic [srdf_pkg::WORD_W-1:0]      rd_data_i,
  output srdf_pkg::srdf_alu_req_t          alu_req_o,
  input  srdf_pkg::srdf_alu_rsp_t          alu_rsp_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RMW  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic [srdf_pkg::CMD_W-1:0]          cmd_q, cmd_d;
  logic [srdf_pkg::IDX_W-1:0]          idx_q, idx_d;
  logic [srdf_pkg::PAY_W-1:0]          arg_q, arg_d;
  logic [srdf_pkg::PAY_W-1:0]          mask_q, mask_d;
  logic [srdf_pkg::DIRTY_BITS-1:0]     dirty_q, dirty_d;
  logic [srdf_pkg::GROUP_SIZE-1:0]     pend_q, pend_d;
  logic [srdf_pkg::WALK_W-1:0]         r_q, r_d;
  logic [srdf_pkg::CNT_W-1:0]          j_q, j_d;
  logic                                issue_done_q, issue_done_d;
  logic                                chk_vld_q, chk_vld_d;
  logic [srdf_pkg::ADDR_W-1:0]         chk_idx_q, chk_idx_d;
  logic                                held_vld_q, held_vld_d;
  logic [srdf_pkg::WORD_W-1:0]         held_word_q, held_word_d;
  logic                                out_vld_q, out_vld_d;
  logic [srdf_pkg::WORD_W-1:0]         out_word_q, out_word_d;
  logic                                out_last_q, out_last_d;

  logic                                accept;
  logic                                out_free;
  logic                                match;
  logic                                fin;
  logic                                stall;
  logic [srdf_pkg::WALK_W-1:0]         r_next;
  srdf_pkg::srdf_mem_req_t             mem_req;

  assign accept   = item_i.valid && item_i.ready;
  assign out_free = !out_vld_q || result_o.ready;
  assign r_next   = r_q + srdf_pkg::WALK_W'(1);
  assign match    = chk_vld_q && alu_rsp_i.eq;
  assign fin      = issue_done_q && !chk_vld_q;
  assign stall    = (match && held_vld_q && !out_free) || (fin && held_vld_q && !out_free);

  always_comb begin
    alu_req_o.cmd  = (state_q == S_WALK) ? srdf_pkg::CMD_FLUSH : cmd_q;
    alu_req_o.idx  = (state_q == S_WALK) ? srdf_pkg::IDX_W'(chk_idx_q) : idx_q;
    alu_req_o.arg  = arg_q;
    alu_req_o.mask = mask_q;
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    arg_d        = arg_q;
    mask_d       = mask_q;
    dirty_d      = dirty_q;
    pend_d       = pend_q;
    r_d          = r_q;
    j_d          = j_q;
    issue_done_d = issue_done_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    held_vld_d   = held_vld_q;
    held_word_d  = held_word_q;
    out_vld_d    = out_vld_q && !result_o.ready;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;
    mem_req      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d  = item_i.cmd;
          idx_d  = item_i.reg_index;
          arg_d  = item_i.arg;
          mask_d = item_i.bit_mask;
          if (item_i.cmd == srdf_pkg::CMD_FLUSH) begin
            if ({1'b0, item_i.group_index} < (srdf_pkg::GRP_W + 1)'(srdf_pkg::NUM_GROUPS)) begin
              for (int g = 0; g < srdf_pkg::NUM_GROUPS; g++) begin
                if (item_i.group_index == srdf_pkg::GRP_W'(g)) begin
                  pend_d = dirty_q[g*srdf_pkg::GROUP_SIZE +: srdf_pkg::GROUP_SIZE];
                  dirty_d[g*srdf_pkg::GROUP_SIZE +: srdf_pkg::GROUP_SIZE] = '0;
                end
              end
              r_d          = srdf_pkg::WALK_W'(item_i.group_index)
                           * srdf_pkg::WALK_W'(srdf_pkg::GROUP_SIZE);
              j_d          = '0;
              issue_done_d = 1'b0;
              chk_vld_d    = 1'b0;
              held_vld_d   = 1'b0;
              state_d      = S_WALK;
            end
          end else if ({1'b0, item_i.reg_index}
                       < (srdf_pkg::IDX_W + 1)'(srdf_pkg::NUM_REGS)) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = item_i.reg_index[srdf_pkg::ADDR_W-1:0];
            state_d         = S_RMW;
          end
        end
      end

      S_RMW: begin
        if (cmd_q == srdf_pkg::CMD_UNCACHED) begin
          if (out_free) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_q[srdf_pkg::ADDR_W-1:0];
            mem_req.wr_data = alu_rsp_i.word;
            for (int i = 0; i < srdf_pkg::NUM_REGS; i++) begin
              if (idx_q == srdf_pkg::IDX_W'(i)) begin
                dirty_d[i] = 1'b0;
              end
            end
            out_vld_d  = 1'b1;
            out_word_d = alu_rsp_i.word;
            out_last_d = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          if (!alu_rsp_i.eq) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_q[srdf_pkg::ADDR_W-1:0];
            mem_req.wr_data = alu_rsp_i.word;
            for (int i = 0; i < srdf_pkg::NUM_REGS; i++) begin
              if (idx_q == srdf_pkg::IDX_W'(i)) begin
                dirty_d[i] = 1'b1;
              end
            end
          end
          state_d = S_IDLE;
        end
      end

      S_WALK: begin
        if (!stall) begin
          if (!issue_done_q) begin
            mem_req.rd_en   = pend_q[0];
            mem_req.rd_addr = r_q[srdf_pkg::ADDR_W-1:0];
            chk_vld_d       = pend_q[0];
            chk_idx_d       = r_q[srdf_pkg::ADDR_W-1:0];
            pend_d          = pend_q >> 1;
            r_d             = r_next;
            j_d             = j_q + srdf_pkg::CNT_W'(1);
            issue_done_d    = (j_q == srdf_pkg::CNT_W'(srdf_pkg::GROUP_SIZE - 1))
                           || (r_next >= srdf_pkg::WALK_W'(srdf_pkg::NUM_REGS));
          end else begin
            chk_vld_d = 1'b0;
          end
          if (match) begin
            held_word_d = rd_data_i;
            held_vld_d  = 1'b1;
            if (held_vld_q) begin
              out_vld_d  = 1'b1;
              out_word_d = held_word_q;
              out_last_d = 1'b0;
            end
          end
          if (fin) begin
            if (held_vld_q) begin
              out_vld_d  = 1'b1;
              out_word_d = held_word_q;
              out_last_d = 1'b1;
            end
            held_vld_d = 1'b0;
            state_d    = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dirty_q      <= '0;
      issue_done_q <= 1'b0;
      chk_vld_q    <= 1'b0;
      held_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      dirty_q      <= dirty_d;
      issue_done_q <= issue_done_d;
      chk_vld_q    <= chk_vld_d;
      held_vld_q   <= held_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    idx_q       <= idx_d;
    arg_q       <= arg_d;
    mask_q      <= mask_d;
    pend_q      <= pend_d;
    r_q         <= r_d;
    j_q         <= j_d;
    chk_idx_q   <= chk_idx_d;
    held_word_q <= held_word_d;
    out_word_q  <= out_word_d;
    out_last_q  <= out_last_d;
  end

  assign mem_req_o             = mem_req;
  assign item_i.ready          = (state_q == S_IDLE);
  assign result_o.valid        = out_vld_q;
  assign result_o.command_word = out_word_q;
  assign result_o.last         = out_last_q;

endmodule

// ===== hdl/shadow_register_dirty_flush.sv =====
// ----------------------------------------------------------------------------
// shadow_register_dirty_flush
// Write-combining shadow register file with dirty tracking and group flush.
// ----------------------------------------------------------------------------
// Write transaction: memory read, then merge/compare and write back; an uncached
//   write's word enters the output register with the write-back, which waits
//   while the output is stalled. The next write is accepted after write-back.
// Flush transaction: one entry per cycle through the read port, unless the
//   output stalls; the group's final word is held back to mark it last.
// Reset clears dirty and entry valid bits at once; no clearing pass.
module shadow_register_dirty_flush (
  input  logic          clk_i,
  input  logic          rst_ni,
  srdf_item_if.sink     item_i,
  srdf_result_if.source result_o
);

  srdf_pkg::srdf_mem_req_t     mem_req;
  srdf_pkg::srdf_alu_req_t     alu_req;
  srdf_pkg::srdf_alu_rsp_t     alu_rsp;
  logic [srdf_pkg::WORD_W-1:0] rd_data;

  srdf_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  srdf_alu u_alu (
    .req_i (alu_req),
    .old_i (rd_data),
    .rsp_o (alu_rsp)
  );

  srdf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .result_o  (result_o),
    .mem_req_o (mem_req),
    .rd_data_i (rd_data),
    .alu_req_o (alu_req),
    .alu_rsp_i (alu_rsp)
  );

  a_no_rd_wr_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("memory read and write in the same cycle");

  a_no_wr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |-> !mem_req.wr_en)
    else $error("memory write while a transaction is accepted");

  a_busy_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.rd_en |=> !item_i.ready)
    else $error("ready while read data is still pending");

endmodule
